// ===== rtl/cmr_pkg.sv =====
package cmr_pkg;

    // Byte buffer geometry
    localparam int BUFFER_BYTES = 4096;
    localparam int BUF_AW = $clog2(BUFFER_BYTES);
    localparam int WP_W = $clog2(BUFFER_BYTES + 1);

    // Item kinds
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Frame type, high nibble of byte 0
    localparam logic [3:0] TYPE_SINGLE = 4'h0;
    localparam logic [3:0] TYPE_FIRST  = 4'h1;
    localparam logic [3:0] TYPE_CONSEC = 4'h2;

    localparam logic [3:0]  FULL_DLC      = 4'd8;
    localparam logic [11:0] FIRST_COUNT   = 12'd6;
    localparam logic [11:0] CONSEC_BYTES  = 12'd7;
    localparam logic [3:0]  START_SINGLE  = 4'd1;
    localparam logic [3:0]  START_FIRST   = 4'd2;

    // Status codes
    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_HELD     = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  frame_dlc;
        logic [7:0]  payload_byte0;
        logic [7:0]  payload_byte1;
        logic [7:0]  payload_byte2;
        logic [7:0]  payload_byte3;
        logic [7:0]  payload_byte4;
        logic [7:0]  payload_byte5;
        logic [7:0]  payload_byte6;
        logic [7:0]  payload_byte7;
        logic [11:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic [11:0] stored_length;
    } out_item_t;

endpackage

// ===== rtl/cmr_in_if.sv =====
interface cmr_in_if;
    import cmr_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cmr_out_if.sv =====
interface cmr_out_if;
    import cmr_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/can_multiframe_reassembler_top.sv =====
// Receive-side reassembler for segmented classic CAN messages (single, first and
// consecutive frames keyed by the high nibble of byte 0). Each input word gives
// exactly one result word. The block takes one word at a time. A well-formed
// frame goes through S_STORE, which writes its payload bytes, and a read through
// S_READ; a malformed frame, a frame ignored while a message is held, a release
// or any other word goes to S_FINISH, where all words end and any stall on the
// result side holds the block. The payload bytes go into the byte buffer one per
// cycle through its single write port, which sets the frame time. A malformed
// frame clears the buffer and counters (status 3); a finished message is held,
// and further frames answer status 2, until a release word frees it.
module can_multiframe_reassembler_top (
    input logic    clk,
    input logic    rst_n,
    cmr_in_if.sink   req,
    cmr_out_if.source rsp
);
    import cmr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_STORE  = 4'b0010,
        S_READ   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rd_data;
    logic       mem_we;
    logic       mem_re;

    state_t      state_reg, state_next;
    logic        ready_reg, ready_next;
    logic [11:0] exp_reg, exp_next;
    logic [11:0] rc_reg, rc_next;
    logic [3:0]  seq_reg, seq_next;
    logic [WP_W-1:0] wp_reg, wp_next;

    logic [7:0]  fb_reg [8];
    logic [3:0]  k_reg, k_next;
    logic [3:0]  end_reg, end_next;
    logic        done_reg, done_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic [7:0]  res_byte_reg, res_byte_next;
    logic        res_valid_reg, res_valid_next;

    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic        accept;
    logic [3:0]  ftype;
    logic        idle_msg;
    logic [3:0]  seq_inc;
    logic [12:0] rc_plus;
    logic        more;
    logic signed [13:0] diff_len;
    logic signed [13:0] dlc_m1;
    logic        rd_hit;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign ftype    = req.data.payload_byte0[7:4];
    assign idle_msg = (rc_reg == 12'd0) && (exp_reg == 12'd0);
    assign seq_inc  = seq_reg + 4'd1;
    assign rc_plus  = {1'b0, rc_reg} + {1'b0, CONSEC_BYTES};
    assign more     = rc_plus < {1'b0, exp_reg};
    assign diff_len = $signed({2'b00, exp_reg}) - $signed({2'b00, rc_reg});
    assign dlc_m1   = $signed({10'd0, req.data.frame_dlc}) - 14'sd1;
    assign rd_hit   = ready_reg
                      && ({1'b0, req.data.read_index} < 13'(wp_reg));

    always_comb
    begin
        state_next      = state_reg;
        ready_next      = ready_reg;
        exp_next        = exp_reg;
        rc_next         = rc_reg;
        seq_next        = seq_reg;
        wp_next         = wp_reg;
        k_next          = k_reg;
        end_next        = end_reg;
        done_next       = done_reg;
        res_status_next = res_status_reg;
        res_byte_next   = res_byte_reg;
        res_valid_next  = res_valid_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_byte_next  = 8'd0;
                    res_valid_next = 1'b0;
                    state_next     = S_FINISH;
                    if (req.data.kind == KIND_FRAME)
                    begin
                        if (ready_reg)
                        begin
                            res_status_next = ST_HELD;
                        end
                        else
                        begin
                            logic bad;
                            bad       = 1'b0;
                            done_next = 1'b0;
                            k_next    = START_SINGLE;
                            end_next  = (req.data.frame_dlc > FULL_DLC) ? FULL_DLC
                                                                       : req.data.frame_dlc;
                            case (ftype)
                                TYPE_SINGLE:
                                begin
                                    if (req.data.frame_dlc == FULL_DLC && idle_msg)
                                        done_next = 1'b1;
                                    else
                                        bad = 1'b1;
                                end
                                TYPE_FIRST:
                                begin
                                    if (req.data.frame_dlc == FULL_DLC && idle_msg)
                                    begin
                                        exp_next = {req.data.payload_byte0[3:0],
                                                    req.data.payload_byte1};
                                        rc_next  = FIRST_COUNT;
                                        seq_next = 4'd0;
                                        k_next   = START_FIRST;
                                    end
                                    else
                                    begin
                                        bad = 1'b1;
                                    end
                                end
                                TYPE_CONSEC:
                                begin
                                    if (rc_reg == 12'd0 || exp_reg == 12'd0)
                                    begin
                                        bad = 1'b1;
                                    end
                                    else
                                    begin
                                        seq_next = seq_inc;
                                        if (seq_inc != req.data.payload_byte0[3:0])
                                            bad = 1'b1;
                                        else if (more && req.data.frame_dlc == FULL_DLC)
                                            rc_next = rc_plus[11:0];
                                        else if (!more && diff_len == dlc_m1)
                                            done_next = 1'b1;
                                        else
                                            bad = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    bad = 1'b1;
                                end
                            endcase
                            if (bad)
                            begin
                                exp_next        = 12'd0;
                                rc_next         = 12'd0;
                                seq_next        = 4'd0;
                                wp_next         = '0;
                                res_status_next = ST_BAD;
                            end
                            else
                            begin
                                state_next = S_STORE;
                            end
                        end
                    end
                    else if (req.data.kind == KIND_READ)
                    begin
                        mem_re          = 1'b1;
                        res_valid_next  = rd_hit;
                        res_status_next = ready_reg ? ST_COMPLETE : ST_BUSY;
                        state_next      = S_READ;
                    end
                    else
                    begin
                        if (req.data.kind == KIND_RELEASE && ready_reg)
                        begin
                            ready_next = 1'b0;
                            wp_next    = '0;
                        end
                        res_status_next = (req.data.kind == KIND_RELEASE || !ready_reg)
                                          ? ST_BUSY : ST_COMPLETE;
                    end
                end
            end
            S_STORE:
            begin
                if (k_reg < end_reg)
                begin
                    // bytes past a full buffer are dropped
                    if (wp_reg < WP_W'(BUFFER_BYTES))
                    begin
                        mem_we  = 1'b1;
                        wp_next = wp_reg + 1'b1;
                    end
                    k_next = k_reg + 4'd1;
                end
                else
                begin
                    if (done_reg)
                    begin
                        ready_next      = 1'b1;
                        exp_next        = 12'd0;
                        rc_next         = 12'd0;
                        seq_next        = 4'd0;
                        res_status_next = ST_COMPLETE;
                    end
                    else
                    begin
                        res_status_next = ST_BUSY;
                    end
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                res_byte_next = res_valid_reg ? rd_data : 8'd0;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = res_status_reg;
                    out_data_next.read_byte     = res_byte_reg;
                    out_data_next.read_valid    = res_valid_reg;
                    out_data_next.stored_length = 12'(wp_reg);
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg[BUF_AW-1:0]] <= fb_reg[k_reg[2:0]];
        end
        if (mem_re)
        begin
            rd_data <= mem[BUF_AW'(req.data.read_index)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fb_reg[0] <= req.data.payload_byte0;
            fb_reg[1] <= req.data.payload_byte1;
            fb_reg[2] <= req.data.payload_byte2;
            fb_reg[3] <= req.data.payload_byte3;
            fb_reg[4] <= req.data.payload_byte4;
            fb_reg[5] <= req.data.payload_byte5;
            fb_reg[6] <= req.data.payload_byte6;
            fb_reg[7] <= req.data.payload_byte7;
        end
        k_reg          <= k_next;
        end_reg        <= end_next;
        done_reg       <= done_next;
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        res_valid_reg  <= res_valid_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= 1'b0;
            exp_reg       <= 12'd0;
            rc_reg        <= 12'd0;
            seq_reg       <= 4'd0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            exp_reg       <= exp_next;
            rc_reg        <= rc_next;
            seq_reg       <= seq_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
